// ===== hdl/lwb_pkg.sv =====
// ----------------------------------------------------------------------------
// lwb_pkg
// Shared types and constants for the line wrap break finder.
// ----------------------------------------------------------------------------
package lwb_pkg;

  localparam int POS_BITS        = 16;   // width of column/offset counters
  localparam int FIELD_BITS      = 16;   // width of offset/column result fields
  localparam int CNT_BITS        = 8;    // break counter width
  localparam int MAX_LINE_BREAKS = 128;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 12;
  localparam int HEUR_SHIFT      = 3;    // heuristic: remaining gap times 8
  localparam int CMP_BITS        = 32;   // heuristic compare width

  // wrap modes
  localparam logic [1:0] MODE_HARD = 2'd0;
  localparam logic [1:0] MODE_HEUR = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BREAKS = 2'd3;

  // character class bits
  localparam int CLS_SPACE = 0;
  localparam int CLS_WORD  = 1;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    pos_t scol;
    pos_t off;
    pos_t col;
  } brk_pos_t;

  typedef struct packed {
    logic [1:0]  break_mode;
    logic [11:0] min_width;
    logic [11:0] max_width;
    logic [7:0]  max_breaks;
  } cfg_t;

  typedef struct packed {
    logic       end_of_line;
    logic       advance_only;
    logic [3:0] char_bytes;
    logic [3:0] glyph_cols;
    logic       is_space_char;
    logic       is_word_char;
  } item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] break_offset;
    logic [FIELD_BITS-1:0] break_column;
    logic [CNT_BITS-1:0]   break_index;
    logic                  is_line_end;
  } result_t;

endpackage

// ===== hdl/line_wrap_break_finder.sv =====
// ----------------------------------------------------------------------------
// line_wrap_break_finder
// Greedy word-wrap break finder: one pre-decoded character per transfer in,
// break records (and an end-of-line record per line unless the break limit silenced it) out.
// ----------------------------------------------------------------------------
//
//  channel   dir  transfer when                  carries
//  --------  ---  -----------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid & s_axis_tready  one character or line end
//  m_axis    out  m_axis_tvalid & m_axis_tready  break record or line-end record
//  cfg       in   cfg_we                         mode / widths / break limit
//
//  Throughput is one character per cycle while the output is not stalled.
//  A transfer lands in the input register; once the result stage can take
//  it, it runs through lwb_core and loads the result register, which offers
//  the record on m_axis.
//  rst is synchronous: clears the line state, both pipeline registers and
//  loads the default configuration (hard cut, min 1, width 80, 128 breaks);
//  s_axis_tready stays low while rst is high.
//  A stalled result holds the input register; characters that give no
//  result still need the result stage free to move on.
//
module line_wrap_break_finder
  import lwb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input characters
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [3:0] char_bytes, [7:4] glyph_cols
  input  logic [2:0]               s_axis_tuser,  // [0] advance_only, [1] is_space_char,
                                                  // [2] is_word_char
  input  logic                     s_axis_tlast,  // end_of_line
  // break records
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [39:0]              m_axis_tdata,  // [15:0] break_offset,
                                                  // [31:16] break_column,
                                                  // [39:32] break_index
  output logic                     m_axis_tlast,  // is_line_end
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  logic    proc;
  logic    core_valid;
  result_t core_res;

  // --- configuration registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_mode <= MODE_HARD;
      cfg.min_width  <= 12'd1;
      cfg.max_width  <= 12'd80;
      cfg.max_breaks <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BREAK_MODE: cfg.break_mode <= cfg_data[1:0];
        REG_MIN_WIDTH:  cfg.min_width  <= cfg_data;
        REG_MAX_WIDTH:  cfg.max_width  <= cfg_data;
        REG_MAX_BREAKS: cfg.max_breaks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item in the input register is applied when the result stage can take it
  assign proc          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || proc);

  // --- input register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.end_of_line   <= s_axis_tlast;
      in_item.advance_only  <= s_axis_tuser[0];
      in_item.char_bytes    <= s_axis_tdata[3:0];
      in_item.glyph_cols    <= s_axis_tdata[7:4];
      in_item.is_space_char <= s_axis_tuser[1];
      in_item.is_word_char  <= s_axis_tuser[2];
    end
  end

  lwb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (proc),
    .item      (in_item),
    .res_valid (core_valid),
    .res       (core_res)
  );

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && core_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && core_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.break_index, out_res.break_column, out_res.break_offset};
  assign m_axis_tlast  = out_res.is_line_end;

endmodule

// ===== hdl/lwb_core.sv =====
// ----------------------------------------------------------------------------
// lwb_core
// Line state registers and the combinational per-character update.
// ----------------------------------------------------------------------------
module lwb_core
  import lwb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,       // apply one item this cycle
  input  item_t   item,
  output logic    res_valid,  // item produces a result
  output result_t res
);

  pos_t                cur_sub_col, cur_sub_col_next;
  pos_t                cur_offset, cur_offset_next;
  pos_t                cur_column, cur_column_next;
  logic [1:0]          cur_class, cur_class_next;
  brk_pos_t            prev_pos, prev_pos_next;
  logic [1:0]          prev_class, prev_class_next;
  brk_pos_t            space_pos, space_pos_next;
  brk_pos_t            word_pos, word_pos_next;
  logic [CNT_BITS-1:0] break_count, break_count_next;
  logic                limit_reached, limit_reached_next;

  logic [1:0]          mode;
  logic [CNT_BITS-1:0] lim;
  logic [11:0]         half_width;
  brk_pos_t            cand;
  logic [POS_BITS:0]   ws_x, ss_x, mw_x;
  logic [CMP_BITS-1:0] gap_ws, gap_mw, gap_tail;

  always_comb begin
    mode = (cfg.break_mode inside {MODE_HEUR, MODE_WORD}) ? cfg.break_mode : MODE_HARD;
    lim  = (cfg.max_breaks == '0 || 32'(cfg.max_breaks) > MAX_LINE_BREAKS)
           ? CNT_BITS'(MAX_LINE_BREAKS) : cfg.max_breaks;
    half_width = 12'((13'(cfg.max_width) + 13'd1) >> 1);
  end

  always_comb begin
    cur_sub_col_next   = cur_sub_col;
    cur_offset_next    = cur_offset;
    cur_column_next    = cur_column;
    cur_class_next     = cur_class;
    prev_pos_next      = prev_pos;
    prev_class_next    = prev_class;
    space_pos_next     = space_pos;
    word_pos_next      = word_pos;
    break_count_next   = break_count;
    limit_reached_next = limit_reached;
    cand      = prev_pos;
    ws_x      = '0;
    ss_x      = '0;
    mw_x      = (POS_BITS+1)'(cfg.max_width);
    gap_ws    = '0;
    gap_mw    = '0;
    gap_tail  = '0;
    res_valid = 1'b0;
    res.break_offset = FIELD_BITS'(cur_offset);
    res.break_column = FIELD_BITS'(cur_column);
    res.break_index  = break_count;
    res.is_line_end  = 1'b1;

    if (item.end_of_line) begin
      // terminating record unless the break limit silenced the line
      res_valid          = !limit_reached;
      cur_sub_col_next   = '0;
      cur_offset_next    = '0;
      cur_column_next    = '0;
      cur_class_next     = '0;
      prev_pos_next      = '0;
      prev_class_next    = '0;
      space_pos_next     = '0;
      word_pos_next      = '0;
      break_count_next   = '0;
      limit_reached_next = 1'b0;
    end else if (!limit_reached) begin
      cur_offset_next = cur_offset + POS_BITS'(item.char_bytes);
      if (!item.advance_only) begin
        cur_class_next = {item.is_word_char, item.is_space_char};
        if (item.glyph_cols == '0) begin
          // combining mark: no break check
          prev_pos_next   = '{cur_sub_col, cur_offset_next, cur_column};
          prev_class_next = cur_class_next;
        end else begin
          cur_column_next  = cur_column + POS_BITS'(item.glyph_cols);
          cur_sub_col_next = cur_sub_col + POS_BITS'(item.glyph_cols);
          if (mode != MODE_HARD) begin
            if (prev_class[CLS_SPACE])
              space_pos_next = prev_pos;
            if (!(prev_class[CLS_WORD] && cur_class_next[CLS_WORD]))
              word_pos_next = prev_pos;
          end
          cand = (mode == MODE_WORD) ? word_pos_next : prev_pos;

          if (cand.scol >= POS_BITS'(cfg.min_width) &&
              cur_sub_col_next > POS_BITS'(cfg.max_width) &&
              (mode != MODE_HEUR || !cur_class_next[CLS_SPACE])) begin
            if (mode == MODE_HEUR && word_pos_next.scol >= POS_BITS'(half_width)) begin
              // prefer the space break when it is close to the word break
              // or the subline is nearly full; differences wrap at 32 bits
              ws_x     = {1'b0, word_pos_next.scol};
              ss_x     = {1'b0, space_pos_next.scol};
              gap_ws   = CMP_BITS'(signed'(ws_x - ss_x));
              gap_mw   = CMP_BITS'(signed'(mw_x - ws_x));
              gap_tail = CMP_BITS'(signed'(mw_x - ss_x)) << HEUR_SHIFT;
              cand = word_pos_next;
              if (space_pos_next.scol >= POS_BITS'(half_width) &&
                  (gap_ws < gap_mw || gap_tail < CMP_BITS'(cfg.max_width)))
                cand = space_pos_next;
            end
            res_valid        = 1'b1;
            res.break_offset = FIELD_BITS'(cand.off);
            res.break_column = FIELD_BITS'(cand.col);
            res.is_line_end  = 1'b0;
            break_count_next = break_count + CNT_BITS'(1);
            if (break_count_next == lim) begin
              limit_reached_next = 1'b1;
            end else begin
              cur_sub_col_next    = cur_sub_col_next - cand.scol;
              word_pos_next.scol  = '0;
              space_pos_next.scol = '0;
              prev_pos_next   = '{cur_sub_col_next, cur_offset_next, cur_column_next};
              prev_class_next = cur_class_next;
            end
          end else begin
            prev_pos_next   = '{cur_sub_col_next, cur_offset_next, cur_column_next};
            prev_class_next = cur_class_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sub_col   <= '0;
      cur_offset    <= '0;
      cur_column    <= '0;
      cur_class     <= '0;
      prev_pos      <= '0;
      prev_class    <= '0;
      space_pos     <= '0;
      word_pos      <= '0;
      break_count   <= '0;
      limit_reached <= 1'b0;
    end else if (step) begin
      cur_sub_col   <= cur_sub_col_next;
      cur_offset    <= cur_offset_next;
      cur_column    <= cur_column_next;
      cur_class     <= cur_class_next;
      prev_pos      <= prev_pos_next;
      prev_class    <= prev_class_next;
      space_pos     <= space_pos_next;
      word_pos      <= word_pos_next;
      break_count   <= break_count_next;
      limit_reached <= limit_reached_next;
    end
  end

endmodule

// ===== bench/tb_line_wrap_break_finder.sv =====
// ----------------------------------------------------------------------------
// tb_line_wrap_break_finder
// Self-checking bench for the greedy word-wrap break finder. A queue of
// characters feeds a stream driver; an in-bench model of the wrap logic
// predicts each break and line-end record, and a monitor checks every output
// transfer against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_line_wrap_break_finder;
  timeunit 1ns;
  timeprecision 1ps;
  import lwb_pkg::*;

  // position snapshot used by the break model: subline col, offset, column, class
  typedef struct packed {
    pos_t       scol;
    pos_t       off;
    pos_t       col;
    logic [1:0] cls;
  } text_pos_t;

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata  = '0;  // [3:0] char_bytes, [7:4] glyph_cols
  logic [2:0]               s_axis_tuser  = '0;  // [0] advance_only, [1] is_space_char,
                                                 // [2] is_word_char
  logic                     s_axis_tlast  = 1'b0; // end_of_line
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [39:0]              m_axis_tdata;        // [15:0] break_offset,
                                                 // [31:16] break_column,
                                                 // [39:32] break_index
  logic                     m_axis_tlast;        // is_line_end
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data      = '0;

  line_wrap_break_finder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  item_t     char_queue[$];      // characters waiting for the driver
  result_t   pending_breaks[$];  // predicted records, oldest first
  int        mismatch_count = 0;
  int        chars_queued   = 0; // counts everything but rendition escapes
  int        src_hold       = 0; // idle cycles before the next input transfer
  int        src_quiet      = 0; // stretch with no input idling
  int        sink_hold      = 0; // stall cycles left on the output side
  int        sink_quiet     = 0;

  // model copy of the configuration registers and the line state
  cfg_t      cfg_shadow;
  pos_t      sub_col, byte_off, line_col;
  logic [1:0] char_cls;
  text_pos_t prev_pos, space_pos, word_pos;
  logic [7:0] breaks_done;
  logic      at_limit;

  // --------------------------------------------------------------------------
  // Break model
  // --------------------------------------------------------------------------
  function automatic void clear_line();
    sub_col     = '0;
    byte_off    = '0;
    line_col    = '0;
    char_cls    = '0;
    prev_pos    = '0;
    space_pos   = '0;
    word_pos    = '0;
    breaks_done = '0;
    at_limit    = 1'b0;
  endfunction

  function automatic text_pos_t here();
    return {sub_col, byte_off, line_col, char_cls};
  endfunction

  // Advances the line state by one character; returns 1 with the record
  // when the character produces one.
  function automatic bit find_break(input item_t it, output result_t rec);
    logic [1:0]  mode;
    int unsigned lim, maxw, half, ws, ss;
    text_pos_t   cand;
    rec  = '0;
    // unused mode 3 falls back to hard cut
    mode = (cfg_shadow.break_mode > MODE_WORD) ? MODE_HARD : cfg_shadow.break_mode;
    lim  = cfg_shadow.max_breaks;
    if (lim == 0 || lim > MAX_LINE_BREAKS) lim = MAX_LINE_BREAKS;
    maxw = cfg_shadow.max_width;
    half = (maxw + 1) / 2;

    if (it.end_of_line) begin
      // line end: record unless the break limit silenced the line
      if (!at_limit) begin
        rec.break_offset = byte_off;
        rec.break_column = line_col;
        rec.break_index  = breaks_done;
        rec.is_line_end  = 1'b1;
        clear_line();
        return 1'b1;
      end
      clear_line();
      return 1'b0;
    end
    if (at_limit) return 1'b0;

    byte_off = byte_off + pos_t'(it.char_bytes);
    if (it.advance_only) return 1'b0;

    char_cls = '0;
    char_cls[CLS_SPACE] = it.is_space_char;
    char_cls[CLS_WORD]  = it.is_word_char;
    // combining mark: just moves the previous position up
    if (it.glyph_cols == 0) begin
      prev_pos = here();
      return 1'b0;
    end
    line_col = line_col + pos_t'(it.glyph_cols);
    sub_col  = sub_col + pos_t'(it.glyph_cols);

    if (mode != MODE_HARD) begin
      if (prev_pos.cls[CLS_SPACE]) space_pos = prev_pos;
      if (!(prev_pos.cls[CLS_WORD] && char_cls[CLS_WORD])) word_pos = prev_pos;
    end
    cand = (mode == MODE_WORD) ? word_pos : prev_pos;

    if (cand.scol >= cfg_shadow.min_width && sub_col > cfg_shadow.max_width &&
        (mode != MODE_HEUR || !char_cls[CLS_SPACE])) begin
      // heuristic: prefer the word boundary past half width, the space when
      // it is close to it or the remaining room is tiny (32-bit wraparound)
      if (mode == MODE_HEUR && int'(word_pos.scol) >= half) begin
        ws   = word_pos.scol;
        ss   = space_pos.scol;
        cand = word_pos;
        if (ss >= half && ((ws - ss) < (maxw - ws) || ((maxw - ss) << HEUR_SHIFT) < maxw))
          cand = space_pos;
      end
      rec.break_offset = cand.off;
      rec.break_column = cand.col;
      rec.break_index  = breaks_done;
      rec.is_line_end  = 1'b0;
      breaks_done = breaks_done + 8'd1;
      if (breaks_done == lim) begin
        at_limit = 1'b1;
        return 1'b1;
      end
      sub_col        = sub_col - cand.scol;
      word_pos.scol  = '0;
      space_pos.scol = '0;
      prev_pos       = here();
      return 1'b1;
    end
    prev_pos = here();
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Idle pattern: mostly none, some short gaps, a few long ones, and now and
  // then a stretch with no idling at all
  // --------------------------------------------------------------------------
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 8) begin
      quiet = $urandom_range(30, 150);
      return 0;
    end
    if (r < 28) return $urandom_range(8, 40);
    if (r < 230) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch (%s): exp off=%0d col=%0d idx=%0d end=%0b, got off=%0d col=%0d idx=%0d end=%0b",
               $time, what, want.break_offset, want.break_column, want.break_index,
               want.is_line_end, got.break_offset, got.break_column, got.break_index,
               got.is_line_end);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input driver: pops the character queue, predicts on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_chars
    item_t   acc;
    item_t   nxt;
    result_t rec;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_hold      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        // rebuild the transfer from the pins, then run the model on it
        acc.end_of_line   = s_axis_tlast;
        acc.advance_only  = s_axis_tuser[0];
        acc.char_bytes    = s_axis_tdata[3:0];
        acc.glyph_cols    = s_axis_tdata[7:4];
        acc.is_space_char = s_axis_tuser[1];
        acc.is_word_char  = s_axis_tuser[2];
        if (find_break(acc, rec)) pending_breaks.push_back(rec);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_hold > 0) begin
          s_axis_tvalid <= 1'b0;
          src_hold      <= src_hold - 1;
        end else if (char_queue.size() > 0) begin
          nxt = char_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.glyph_cols, nxt.char_bytes};
          s_axis_tuser  <= {nxt.is_word_char, nxt.is_space_char, nxt.advance_only};
          s_axis_tlast  <= nxt.end_of_line;
          src_hold      <= idle_len(src_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor with random back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_records
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.break_offset = m_axis_tdata[15:0];
        got.break_column = m_axis_tdata[31:16];
        got.break_index  = m_axis_tdata[39:32];
        got.is_line_end  = m_axis_tlast;
        if (pending_breaks.size() == 0) begin
          report_mismatch("unexpected record", '0, got);
        end else begin
          want = pending_breaks.pop_front();
          if (got.break_offset !== want.break_offset ||
              got.break_column !== want.break_column ||
              got.break_index  !== want.break_index  ||
              got.is_line_end  !== want.is_line_end)
            report_mismatch("field", want, got);
        end
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold     <= sink_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_hold     <= idle_len(sink_quiet);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_char(input bit eol, input bit adv, input int nbytes,
                            input int width, input bit sp, input bit wd);
    item_t it;
    it.end_of_line   = eol;
    it.advance_only  = adv;
    it.char_bytes    = nbytes[3:0];
    it.glyph_cols    = width[3:0];
    it.is_space_char = sp;
    it.is_word_char  = wd;
    char_queue.push_back(it);
    if (!adv || eol) chars_queued++;
  endtask

  // Wait until every queued character went in and every record came out,
  // then let no-result characters still in the pipe settle.
  // Sampled on the falling edge so the driver's updates have landed.
  task automatic drain();
    int guard;
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while ((char_queue.size() != 0 || s_axis_tvalid || pending_breaks.size() != 0)
               && guard < 100000);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // all four registers, written only once the block has gone idle
  task automatic set_config(input logic [1:0] mode, input logic [11:0] minw,
                            input logic [11:0] maxw, input logic [7:0] brk);
    drain();
    write_reg(REG_BREAK_MODE, 12'(mode));
    write_reg(REG_MIN_WIDTH,  minw);
    write_reg(REG_MAX_WIDTH,  maxw);
    write_reg(REG_MAX_BREAKS, 12'(brk));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow = {mode, minw, maxw, brk};
  endtask

  // text-like line: word runs, space runs, odd punctuation, a few wide or
  // combining characters and rendition escapes, then a line end
  task automatic random_line();
    int         len, run, k, w, nb, i;
    logic [1:0] cls;
    len = $urandom_range(4, 70);
    run = 0;
    cls = '0;
    for (i = 0; i < len; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) begin
        queue_char(1'b0, 1'b1, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (k < 8) begin
        queue_char(1'b0, 1'b0, $urandom_range(1, 3), 0, cls[CLS_SPACE], cls[CLS_WORD]);
      end else begin
        if (run == 0) begin
          k   = $urandom_range(0, 9);
          cls = '0;
          if (k < 6) begin
            cls[CLS_WORD] = 1'b1;
            run = $urandom_range(1, 9);
          end else if (k < 9) begin
            cls[CLS_SPACE] = 1'b1;
            run = $urandom_range(1, 2);
          end else begin
            cls = 2'($urandom_range(0, 3));
            run = 1;
          end
        end
        run--;
        k = $urandom_range(0, 99);
        if (k < 3) begin
          w  = $urandom_range(0, 15);
          nb = $urandom_range(0, 15);
        end else if (k < 13) begin
          w  = 2;
          nb = 3;
        end else begin
          w  = 1;
          nb = $urandom_range(1, 2);
        end
        queue_char(1'b0, 1'b0, nb, w, cls[CLS_SPACE], cls[CLS_WORD]);
      end
    end
    // other fields of a line end are don't-care
    queue_char(1'b1, $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // unstructured items, including stray line ends
  task automatic noise_items(input int n);
    repeat (n)
      queue_char($urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    string       phrase;
    int          i, k, target;
    logic [1:0]  mode;
    logic [11:0] minw, maxw;
    logic [7:0]  brk;
    clear_line();
    cfg_shadow = {MODE_HARD, 12'd1, 12'd80, 8'd128};   // reset defaults
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // -- directed ------------------------------------------------------------
    // reset config: empty line end, then one max-size character
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
    queue_char(1'b0, 1'b0, 15, 15, 1'b1, 1'b1);
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

    // hard cut at width 4, limit 2: combining mark, escape, limit silence
    set_config(MODE_HARD, 12'd1, 12'd4, 8'd2);
    repeat (3) queue_char(1'b0, 1'b0, 1, 1, 1'b0, 1'b1);
    queue_char(1'b0, 1'b0, 2, 0, 1'b0, 1'b1);     // combining mark
    queue_char(1'b0, 1'b0, 3, 2, 1'b0, 1'b1);     // first break
    queue_char(1'b0, 1'b1, 15, 15, 1'b1, 1'b1);   // escape: offset only
    queue_char(1'b0, 1'b0, 15, 15, 1'b1, 1'b1);   // second break hits the limit
    queue_char(1'b0, 1'b0, 1, 1, 1'b0, 1'b1);     // ignored after limit
    queue_char(1'b1, 1'b1, 15, 15, 1'b1, 1'b1);   // line end, no record
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

    // heuristic, min 0, break limit 0 means the built-in maximum
    set_config(MODE_HEUR, 12'd0, 12'd8, 8'd0);
    phrase = "ab cd efg hij k";
    for (i = 0; i < phrase.len(); i++)
      queue_char(1'b0, 1'b0, 1, 1, phrase[i] == " ", phrase[i] != " ");
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

    // unused mode, min at its top, width 1, limit above the maximum
    set_config(2'd3, 12'd4095, 12'd1, 8'd200);
    repeat (3) queue_char(1'b0, 1'b0, 1, 1, 1'b0, 1'b1);
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

    // word boundary, width 1, limit 1
    set_config(MODE_WORD, 12'd0, 12'd1, 8'd1);
    queue_char(1'b0, 1'b0, 1, 1, 1'b0, 1'b1);
    queue_char(1'b0, 1'b0, 1, 1, 1'b1, 1'b0);
    queue_char(1'b0, 1'b0, 1, 1, 1'b0, 1'b1);
    queue_char(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

    // -- random ---------------------------------------------------------------
    target = chars_queued + 1200;
    while (chars_queued < target) begin
      k = $urandom_range(0, 9);
      mode = (k == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      k = $urandom_range(0, 19);
      maxw = (k < 2) ? 12'd1 : (k < 3) ? 12'd4095 : 12'($urandom_range(2, 40));
      k = $urandom_range(0, 19);
      minw = (k < 2) ? 12'd0 : (k < 3) ? 12'd4095 : (k < 5) ? maxw
           : 12'($urandom_range(0, maxw / 2));
      k = $urandom_range(0, 19);
      brk = (k < 2) ? 8'd0 : (k < 3) ? 8'd255 : (k < 5) ? 8'd1 : (k < 7) ? 8'd128
          : 8'($urandom_range(1, 12));
      set_config(mode, minw, maxw, brk);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) < 8) random_line();
        else noise_items($urandom_range(5, 30));
      end
    end

    // -- wrap up -------------------------------------------------------------
    drain();
    if (pending_breaks.size() != 0) begin
      mismatch_count++;
      $display("%0t %0d predicted records never arrived", $time, pending_breaks.size());
    end
    if (mismatch_count == 0) begin
      $display("[line_wrap_break_finder] OK");
    end else begin
      $display("[line_wrap_break_finder] ERROR");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #40ms;
    $display("[line_wrap_break_finder] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lwb_pkg.sv
hdl/lwb_core.sv
hdl/line_wrap_break_finder.sv
bench/tb_line_wrap_break_finder.sv
